// ===== hdl/bsc_pkg.sv =====
// Shared types and fixed widths for the bit string copy block.
package bsc_pkg;

  typedef enum logic [1:0] {
    ACT_WR_SRC = 2'd0,
    ACT_WR_DST = 2'd1,
    ACT_RD_DST = 2'd2,
    ACT_COPY   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_COPY,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  // Byte indexes reached by an 11-bit offset plus a 12-bit length.
  localparam int IDX_W = 10;
  // Wide enough for any store depth, and for any store size in bits.
  localparam int EXT_W = 17;
  localparam int BIT_W = 20;

endpackage

// ===== hdl/bit_string_copy.sv =====
// Top level of the bit string copy block: two byte stores and the copy engine.
//
// Usage: one input word carries an action and its operands; every word yields
// exactly one result word. Writes store a byte into the source or destination
// store, a read returns a destination byte, and a copy moves a run of bits,
// numbered from the MSB of each byte, from the source store into the
// destination store while leaving the neighboring destination bits alone.
// A copy that would run past either store flags range_error and changes
// nothing.
// Sequence: a write or a rejected or empty copy goes from acceptance straight
// to the result state, and a read passes through a read state first. A copy
// primes the source store, then reads, merges and writes back the destination
// memory one byte per cycle, which sets its pace, and drains the last merged
// byte before its result, so the input stays stalled for the whole copy.
// The block works on one word at a time; in_stall is high from acceptance
// until the result has moved into the output register. The output register
// holds a finished result while out_stall is high, and a new input word is
// accepted in the meantime. Reset clears the control state only; the stores
// hold unknown data until written.
module bit_string_copy #(
  parameter int STORE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  byte_address,
  input  logic [7:0]  byte_value,
  input  logic [10:0] dest_bit_offset,
  input  logic [10:0] source_bit_offset,
  input  logic [11:0] run_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_value,
  output logic        range_error
);
  import bsc_pkg::*;

  localparam int AW = (STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1;
  localparam logic [EXT_W-1:0] DEPTH      = EXT_W'(STORE_BYTES);
  localparam logic [BIT_W-1:0] TOTAL_BITS = BIT_W'(STORE_BYTES * 8);

  logic [7:0] src_mem [STORE_BYTES];
  logic [7:0] dst_mem [STORE_BYTES];
  logic [7:0] src_q;
  logic [7:0] dst_q;
  logic [7:0] prev;

  state_t state, state_next;

  // Decode of the incoming word.
  action_t                  in_act;
  logic                     in_acc;
  logic                     addr_ok;
  logic                     range_bad;
  logic [12:0]              end_bit;
  logic [IDX_W-1:0]         d_first;
  logic [IDX_W-1:0]         d_last;
  logic [IDX_W-1:0]         nbytes;
  logic signed [12:0]       sdiff;

  // Copy sequencing.
  logic [2:0]               shift;
  logic [2:0]               first_lo;
  logic [2:0]               last_hi;
  logic signed [IDX_W-1:0]  src_idx;
  logic [IDX_W-1:0]         dst_idx;
  logic [IDX_W-1:0]         rd_left;
  logic                     issue_first;
  logic                     src_v;
  logic                     p_v;
  logic                     p_first;
  logic                     p_last;
  logic [IDX_W-1:0]         p_addr;

  logic [7:0]               res_value;
  logic                     res_error;
  logic                     out_free;

  // Memory port controls.
  logic                     src_we;
  logic                     src_re;
  logic                     dst_we;
  logic                     dst_re;
  logic [IDX_W-1:0]         dst_ra;
  logic [IDX_W-1:0]         dst_wa;
  logic [7:0]               dst_wd;
  logic [EXT_W-1:0]         src_ra_ext;
  logic [EXT_W-1:0]         dst_ra_ext;
  logic [EXT_W-1:0]         dst_wa_ext;
  logic [EXT_W-1:0]         src_wa_ext;

  logic [15:0]              window;
  logic [7:0]               new_byte;
  logic [7:0]               mask;
  logic [7:0]               merged;

  assign in_act    = action_t'(action);
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign addr_ok   = EXT_W'(byte_address) < DEPTH;
  assign range_bad = (BIT_W'(source_bit_offset) + BIT_W'(run_length) > TOTAL_BITS) ||
                     (BIT_W'(dest_bit_offset) + BIT_W'(run_length) > TOTAL_BITS);
  assign end_bit   = 13'(dest_bit_offset) + 13'(run_length) - 13'd1;
  assign d_first   = IDX_W'(dest_bit_offset[10:3]);
  assign d_last    = end_bit[12:3];
  assign nbytes    = d_last - d_first + IDX_W'(1);
  // Source bit that lands on the MSB of the first destination byte; it may
  // lie before the store, but such bits fall outside the run and are masked.
  assign sdiff     = $signed({2'b00, source_bit_offset}) -
                     $signed({10'b0, dest_bit_offset[2:0]});

  // Funnel the two latest source bytes onto the destination byte alignment.
  assign window   = {prev, src_q} << shift;
  assign new_byte = window[15:8];

  always_comb begin
    logic [2:0] lo;
    logic [2:0] hi;
    logic [2:0] b;
    lo = p_first ? first_lo : 3'd0;
    hi = p_last ? last_hi : 3'd7;
    for (int i = 0; i < 8; i++) begin
      b = 3'(7 - i);
      mask[i] = (b >= lo) && (b <= hi);
    end
    merged = (dst_q & ~mask) | (new_byte & mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    src_we     = 1'b0;
    src_re     = 1'b0;
    dst_we     = 1'b0;
    dst_re     = 1'b0;
    dst_ra     = dst_idx;
    dst_wa     = p_addr;
    dst_wd     = merged;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_act)
            ACT_WR_SRC: begin
              src_we     = addr_ok;
              state_next = ST_RESULT;
            end
            ACT_WR_DST: begin
              dst_we     = addr_ok;
              dst_wa     = IDX_W'(byte_address);
              dst_wd     = byte_value;
              state_next = ST_RESULT;
            end
            ACT_RD_DST: begin
              dst_re     = addr_ok;
              dst_ra     = IDX_W'(byte_address);
              state_next = addr_ok ? ST_READ : ST_RESULT;
            end
            ACT_COPY: begin
              state_next = (range_bad || run_length == '0) ? ST_RESULT : ST_PRIME;
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_PRIME: begin
        src_re     = 1'b1;
        state_next = ST_COPY;
      end
      ST_COPY: begin
        src_re = 1'b1;
        dst_re = 1'b1;
        dst_we = p_v;
        if (rd_left == IDX_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dst_we     = p_v;
        state_next = ST_RESULT;
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign src_ra_ext = EXT_W'(src_idx);
  assign src_wa_ext = EXT_W'(byte_address);
  assign dst_ra_ext = EXT_W'(dst_ra);
  assign dst_wa_ext = EXT_W'(dst_wa);

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_wa_ext[AW-1:0]] <= byte_value;
    end
    if (src_re) begin
      src_q <= src_mem[src_ra_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dst_we) begin
      dst_mem[dst_wa_ext[AW-1:0]] <= dst_wd;
    end
    if (dst_re) begin
      dst_q <= dst_mem[dst_ra_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_v     <= 1'b0;
      p_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      src_v <= src_re;
      p_v   <= (state == ST_COPY);
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_v) begin
      prev <= src_q;
    end
    if (in_acc) begin
      res_value   <= '0;
      res_error   <= (in_act == ACT_COPY) && range_bad;
      shift       <= sdiff[2:0];
      first_lo    <= dest_bit_offset[2:0];
      last_hi     <= end_bit[2:0];
      src_idx     <= sdiff[12:3];
      dst_idx     <= d_first;
      rd_left     <= nbytes;
      issue_first <= 1'b1;
    end
    if (state == ST_PRIME) begin
      src_idx <= src_idx + IDX_W'(1);
    end
    if (state == ST_COPY) begin
      src_idx     <= src_idx + IDX_W'(1);
      dst_idx     <= dst_idx + IDX_W'(1);
      rd_left     <= rd_left - IDX_W'(1);
      issue_first <= 1'b0;
      p_first     <= issue_first;
      p_last      <= (rd_left == IDX_W'(1));
      p_addr      <= dst_idx;
    end
    if (state == ST_READ) begin
      res_value <= dst_q;
    end
    if (state == ST_RESULT && out_free) begin
      read_value  <= res_value;
      range_error <= res_error;
    end
  end

  // A merge write only follows a read issued by the copy loop.
  a_merge_after_issue: assert property (@(posedge clk) disable iff (rst)
    p_v |-> ($past(state) == ST_COPY) && (state == ST_COPY || state == ST_DRAIN))
    else $error("merge stage valid outside a copy");

  a_drain_has_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> p_v && p_last)
    else $error("drain without the last destination byte in flight");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> rd_left != '0)
    else $error("copy loop running with no bytes left");

  a_read_no_error: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !res_error)
    else $error("range error raised on a read");

endmodule

// ===== tb/bit_copy_checker.sv =====
// Checker for the bit string copy block: mirrors both stores and compares every result word.
module bit_copy_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  byte_address,
  input  logic [7:0]  byte_value,
  input  logic [10:0] dest_bit_offset,
  input  logic [10:0] source_bit_offset,
  input  logic [11:0] run_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_value,
  input  logic        range_error,
  output int          fail_count,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int STORE_BYTES = 256;
  localparam int STORE_BITS  = STORE_BYTES * 8;

  typedef struct {
    logic [7:0] read_value;
    logic       range_error;
  } outcome_t;

  logic [7:0] src_mirror [STORE_BYTES];
  logic [7:0] dst_mirror [STORE_BYTES];
  outcome_t   due_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what);
    if (fail_count < 100) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    fail_count = fail_count + 1;
  endtask

  // Updates the mirrored stores for one input word and returns its result word.
  function automatic outcome_t apply_word(action_t act, logic [7:0] addr, logic [7:0] val,
                                          int unsigned dofs, int unsigned sofs,
                                          int unsigned len);
    outcome_t    res;
    int unsigned sp;
    int unsigned dp;
    res.read_value = 8'd0;
    res.range_error = 1'b0;
    case (act)
      ACT_WR_SRC: src_mirror[addr] = val;
      ACT_WR_DST: dst_mirror[addr] = val;
      ACT_RD_DST: res.read_value = dst_mirror[addr];
      default: begin
        if (sofs + len > STORE_BITS || dofs + len > STORE_BITS) begin
          res.range_error = 1'b1;
        end else begin
          // Bits are numbered from the MSB of each byte.
          for (int unsigned i = 0; i < len; i++) begin
            sp = sofs + i;
            dp = dofs + i;
            dst_mirror[8'(dp >> 3)][3'(7 - (dp & 7))] =
              src_mirror[8'(sp >> 3)][3'(7 - (sp & 7))];
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      due_results.delete();
    end else begin
      // The result side is handled first so a word accepted on this edge
      // can never satisfy an early result.
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with no word outstanding");
        end else begin
          want = due_results.pop_front();
          if (read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h", read_value,
                                      want.read_value));
          end
          if (range_error !== want.range_error) begin
            report_mismatch($sformatf("range_error %b, expected %b", range_error,
                                      want.range_error));
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_word(action_t'(action), byte_address, byte_value,
                                         32'(dest_bit_offset), 32'(source_bit_offset),
                                         32'(run_length)));
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/bit_string_copy_tb.sv =====
// Stimulus and verdict for the bit string copy block.
module bit_string_copy_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = 2'd0;
  logic [7:0]  byte_address = 8'd0;
  logic [7:0]  byte_value = 8'd0;
  logic [10:0] dest_bit_offset = 11'd0;
  logic [10:0] source_bit_offset = 11'd0;
  logic [11:0] run_length = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  read_value;
  logic        range_error;
  int          fail_count;
  int          pending;

  // When set, the matching side runs without idle cycles.
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  int unsigned span_lo = 0;
  int unsigned span_hi = 0;

  bit_string_copy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .byte_address(byte_address), .byte_value(byte_value),
    .dest_bit_offset(dest_bit_offset), .source_bit_offset(source_bit_offset),
    .run_length(run_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .range_error(range_error)
  );

  bit_copy_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .byte_address(byte_address), .byte_value(byte_value),
    .dest_bit_offset(dest_bit_offset), .source_bit_offset(source_bit_offset),
    .run_length(run_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .range_error(range_error),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("bit_string_copy test failed");
    $finish;
  end

  // Called and left at a falling edge; valid stays high across back-to-back words.
  task automatic send_word(action_t act, int unsigned addr, int unsigned val,
                           int unsigned dofs, int unsigned sofs, int unsigned len);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    byte_address = 8'(addr);
    byte_value = 8'(val);
    dest_bit_offset = 11'(dofs);
    source_bit_offset = 11'(sofs);
    run_length = 12'(len);
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_copy(int unsigned dofs, int unsigned sofs, int unsigned len);
    span_lo = dofs >> 3;
    span_hi = (len == 0) ? span_lo : (dofs + len - 1) >> 3;
    if (span_hi > 255) span_hi = 255;
    send_word(ACT_COPY, $urandom, $urandom, dofs, sofs, len);
  endtask

  task automatic send_read(int unsigned addr);
    send_word(ACT_RD_DST, addr, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Result side: a random stall before each result word is taken.
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int          pick;
    int unsigned len;
    int unsigned dofs;
    int unsigned sofs;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Fill both stores so that no read or copy ever touches an unwritten byte.
    for (int unsigned a = 0; a < 256; a++) begin
      send_word(ACT_WR_SRC, a, $urandom, $urandom, $urandom, $urandom);
      send_word(ACT_WR_DST, a, $urandom, $urandom, $urandom, $urandom);
    end
    wait_drained();

    // Directed words: store edges, partial bytes, exact fits and overruns.
    send_word(ACT_WR_SRC, 0, 'hA5, 'h7FF, 'h7FF, 'hFFF);
    send_word(ACT_WR_SRC, 255, 'hFF, 0, 0, 0);
    send_word(ACT_WR_DST, 0, 'h00, 'h555, 'h2AA, 'hAAA);
    send_word(ACT_WR_DST, 255, 'hFF, 'h2AA, 'h555, 'h555);
    send_read(0);
    send_read(255);
    send_copy(0, 0, 0);
    send_copy(3, 5, 1);
    send_read(0);
    send_copy(2047, 2047, 1);
    send_read(255);
    send_copy(0, 0, 2048);
    send_read(0);
    send_read(128);
    send_copy(1, 0, 2048);
    send_copy(0, 1, 2048);
    send_copy(2047, 2047, 4095);
    send_copy(0, 2047, 2);
    send_copy(6, 13, 20);
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(3);
    send_copy(1000, 0, 1048);
    send_read(255);
    wait_drained();

    for (int n = 0; n < 610; n++) begin
      if (n % 64 == 0) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      if (n % 200 == 199) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(ACT_WR_SRC, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 27) begin
        send_word(ACT_WR_DST, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 62) begin
        // Most reads look at the bytes the last copy wrote.
        if ($urandom_range(0, 9) < 6) begin
          send_read($urandom_range(span_lo, span_hi));
        end else begin
          send_read($urandom_range(0, 255));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          len = $urandom_range(1, 40);
        end else if (pick < 75) begin
          len = $urandom_range(0, 300);
        end else if (pick < 80) begin
          len = $urandom_range(1500, 2048);
        end else begin
          len = 0;
        end
        if (pick < 85) begin
          dofs = $urandom_range(0, 2048 - len);
          sofs = $urandom_range(0, 2048 - len);
          if (len == 0) begin
            dofs = $urandom_range(0, 2047);
            sofs = $urandom_range(0, 2047);
          end
        end else begin
          // Arbitrary operands, most of them running past a store.
          dofs = $urandom_range(0, 2047);
          sofs = $urandom_range(0, 2047);
          len = $urandom_range(0, 4095);
        end
        send_copy(dofs, sofs, len);
      end
    end

    wait_drained();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bit_string_copy test passed");
    end else begin
      $display("bit_string_copy test failed");
    end
    $finish;
  end

endmodule
